### hdl/gabc_pkg.sv
// ----------------------------------------------------------------------------
// gabc_pkg
// Shared types and constants for the glyph alpha blend and clip pipeline.
// ----------------------------------------------------------------------------
package gabc_pkg;

  // glyph index limit; compares are done at a width that covers the largest value
  localparam int unsigned GLYPH_MAX_SIDE = 256;
  localparam int unsigned GLYPH_IDX_W    = 11;

  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PROD_W   = 2 * CHAN_W;

  // near-color tolerances: a channel distance must stay strictly below these
  localparam logic [CHAN_W-1:0] TOL_RB_565 = 8'd4;
  localparam logic [CHAN_W-1:0] TOL_G_565  = 8'd5;
  localparam logic [CHAN_W-1:0] TOL_32     = 8'd24;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // channel slots in the per-channel arrays
  localparam int unsigned CH_B = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_R = 2;

  typedef enum logic [2:0] {
    CFG_TEXT_COLOR   = 3'd0,
    CFG_FRAME_WIDTH  = 3'd1,
    CFG_FRAME_HEIGHT = 3'd2,
    CFG_PIXEL_FORMAT = 3'd3,
    CFG_SKIP_NEAR    = 3'd4,
    CFG_CLIP_BOX     = 3'd5
  } gabc_cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_BGRA32 = 2'd1
  } gabc_fmt_e;

  typedef struct packed {
    logic [23:0] text_color;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [1:0]  pixel_format;
    logic        skip_near_color;
    logic [63:0] clip_box;
  } gabc_cfg_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         glyph_col;
    logic [7:0]         glyph_row;
    logic [7:0]         coverage;
    logic [31:0]        dest_pixel;
  } gabc_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] new_pixel;
  } gabc_out_t;

  // after unpack: frame position, channel distances to the text color
  typedef struct packed {
    logic signed [16:0]                     fx;
    logic signed [16:0]                     fy;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]        chan;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]        mag;
    logic [NUM_CHAN-1:0]                    neg;
    logic [CHAN_W-1:0]                      coverage;
    logic                                   pre_ok;
  } gabc_s1_t;

  // after position tests and the coverage multiply
  typedef struct packed {
    logic                                   ok;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]        chan;
    logic [NUM_CHAN-1:0]                    neg;
    logic [NUM_CHAN-1:0][PROD_W-1:0]        prod;
  } gabc_s2_t;

endpackage

### hdl/gabc_unpack.sv
// ----------------------------------------------------------------------------
// gabc_unpack
// Stage one: frame position, channel unpack, distance to the text color and
// the early reject terms (glyph index, zero coverage, format, near color).
// ----------------------------------------------------------------------------
module gabc_unpack import gabc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  gabc_cfg_t cfg_i,
  input  logic      valid_i,
  input  gabc_in_t  data_i,
  output logic      valid_o,
  output gabc_s1_t  data_o
);

  logic                            valid_q;
  gabc_s1_t                        data_q, data_d;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] text;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] tol;
  logic [NUM_CHAN-1:0]             close;
  logic                            is_565;
  logic                            idx_ok;

  assign is_565 = (cfg_i.pixel_format == FMT_RGB565);

  always_comb begin
    text[CH_R] = cfg_i.text_color[23:16];
    text[CH_G] = cfg_i.text_color[15:8];
    text[CH_B] = cfg_i.text_color[7:0];
    if (is_565) begin
      chan[CH_R] = {data_i.dest_pixel[15:11], 3'b000};
      chan[CH_G] = {data_i.dest_pixel[10:5], 2'b00};
      chan[CH_B] = {data_i.dest_pixel[4:0], 3'b000};
      tol[CH_R]  = TOL_RB_565;
      tol[CH_G]  = TOL_G_565;
      tol[CH_B]  = TOL_RB_565;
    end else begin
      chan[CH_R] = data_i.dest_pixel[23:16];
      chan[CH_G] = data_i.dest_pixel[15:8];
      chan[CH_B] = data_i.dest_pixel[7:0];
      tol[CH_R]  = TOL_32;
      tol[CH_G]  = TOL_32;
      tol[CH_B]  = TOL_32;
    end
  end

  assign idx_ok = (GLYPH_IDX_W'(data_i.glyph_col) < GLYPH_IDX_W'(GLYPH_MAX_SIDE)) &&
                  (GLYPH_IDX_W'(data_i.glyph_row) < GLYPH_IDX_W'(GLYPH_MAX_SIDE));

  always_comb begin
    data_d = '0;
    data_d.fx = 17'(data_i.origin_x) + $signed({9'b0, data_i.glyph_col});
    data_d.fy = 17'(data_i.origin_y) + $signed({9'b0, data_i.glyph_row});
    for (int i = 0; i < NUM_CHAN; i++) begin
      // distance as magnitude plus sign, so the multiply stays unsigned
      data_d.neg[i] = (chan[i] > text[i]);
      data_d.mag[i] = data_d.neg[i] ? (chan[i] - text[i]) : (text[i] - chan[i]);
      close[i]      = (data_d.mag[i] < tol[i]);
    end
    data_d.chan     = chan;
    data_d.coverage = data_i.coverage;
    data_d.pre_ok   = idx_ok && (data_i.coverage != '0) &&
                      (cfg_i.pixel_format == FMT_RGB565 ||
                       cfg_i.pixel_format == FMT_BGRA32) &&
                      !(cfg_i.skip_near_color && (&close));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/gabc_test.sv
// ----------------------------------------------------------------------------
// gabc_test
// Stage two: frame and clip box tests and the coverage multiply per channel.
// ----------------------------------------------------------------------------
module gabc_test import gabc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  gabc_cfg_t cfg_i,
  input  logic      valid_i,
  input  gabc_s1_t  data_i,
  output logic      valid_o,
  output gabc_s2_t  data_o
);

  logic               valid_q;
  gabc_s2_t           data_q, data_d;
  logic signed [17:0] fx, fy;
  logic signed [17:0] fw, fh;
  logic signed [17:0] cx_lo, cy_lo, cx_hi, cy_hi;
  logic [16:0]        cx_end, cy_end;
  logic               in_frame, clip_on, in_clip;

  assign fx = 18'(data_i.fx);
  assign fy = 18'(data_i.fy);
  assign fw = $signed({2'b00, cfg_i.frame_width});
  assign fh = $signed({2'b00, cfg_i.frame_height});

  // clip extent is formed without wrap
  assign cx_end = {1'b0, cfg_i.clip_box[63:48]} + {1'b0, cfg_i.clip_box[31:16]};
  assign cy_end = {1'b0, cfg_i.clip_box[47:32]} + {1'b0, cfg_i.clip_box[15:0]};
  assign cx_lo  = $signed({2'b00, cfg_i.clip_box[63:48]});
  assign cy_lo  = $signed({2'b00, cfg_i.clip_box[47:32]});
  assign cx_hi  = $signed({1'b0, cx_end});
  assign cy_hi  = $signed({1'b0, cy_end});

  assign in_frame = (fx >= 18'sd0) && (fx < fw) && (fy >= 18'sd0) && (fy < fh);
  assign clip_on  = (cfg_i.clip_box[31:16] != '0) && (cfg_i.clip_box[15:0] != '0);
  assign in_clip  = (fx >= cx_lo) && (fx < cx_hi) && (fy >= cy_lo) && (fy < cy_hi);

  always_comb begin
    data_d      = '0;
    data_d.ok   = data_i.pre_ok && in_frame && (!clip_on || in_clip);
    data_d.chan = data_i.chan;
    data_d.neg  = data_i.neg;
    for (int i = 0; i < NUM_CHAN; i++) begin
      data_d.prod[i] = data_i.mag[i] * data_i.coverage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/gabc_mix.sv
// ----------------------------------------------------------------------------
// gabc_mix
// Stage three: divide by 255 with truncation toward zero, apply to each
// channel, repack in the configured format. Holds the output register.
// ----------------------------------------------------------------------------
module gabc_mix import gabc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  gabc_cfg_t cfg_i,
  input  logic      valid_i,
  input  gabc_s2_t  data_i,
  output logic      valid_o,
  output gabc_out_t data_o
);

  logic                            valid_q;
  gabc_out_t                       data_q, data_d;
  logic [NUM_CHAN-1:0][PROD_W:0]   sum;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] quo;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] res;

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      // m / 255 == (m + 1 + (m >> 8)) >> 8, exact for m up to 255 * 255
      sum[i] = {1'b0, data_i.prod[i]} + (PROD_W + 1)'(1) +
               (PROD_W + 1)'(data_i.prod[i][PROD_W-1:CHAN_W]);
      quo[i] = sum[i][PROD_W-1:CHAN_W];
      res[i] = data_i.neg[i] ? (data_i.chan[i] - quo[i]) : (data_i.chan[i] + quo[i]);
    end
  end

  always_comb begin
    data_d = '0;
    if (data_i.ok) begin
      data_d.write_enable = 1'b1;
      if (cfg_i.pixel_format == FMT_RGB565) begin
        data_d.new_pixel = {16'h0000, res[CH_R][7:3], res[CH_G][7:2], res[CH_B][7:3]};
      end else begin
        data_d.new_pixel = {ALPHA_OPAQUE, res[CH_R], res[CH_G], res[CH_B]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/glyph_alpha_blend_clip_top.sv
// ----------------------------------------------------------------------------
// glyph_alpha_blend_clip_top
// Blends glyph coverage pixels into destination pixels with frame and clip
// box rejection, for RGB565 and 32-bit BGRA surfaces.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   in        input       in_valid_i/in_stall_o  gabc_in_t  (one glyph pixel)
//   out       output      out_valid_o/out_stall_i gabc_out_t (write flag, pixel)
//   cfg       input       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// one beat in and one beat out per cycle while the output is not stalled; a
// result passes the unpack, test/multiply and divide/repack stages in order.
// reset clears the configuration registers and all stage valid bits.
// when the output register holds a beat that is stalled, every stage holds
// and in_stall_o is raised in the same cycle.
// ----------------------------------------------------------------------------
module glyph_alpha_blend_clip_top import gabc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  gabc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output gabc_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  gabc_cfg_t cfg_q;
  logic      adv;
  logic      s1_valid, s2_valid;
  gabc_s1_t  s1_data;
  gabc_s2_t  s2_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gabc_cfg_idx_e'(cfg_index_i))
        CFG_TEXT_COLOR:   cfg_q.text_color      <= cfg_wdata_i[23:0];
        CFG_FRAME_WIDTH:  cfg_q.frame_width     <= cfg_wdata_i[15:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height    <= cfg_wdata_i[15:0];
        CFG_PIXEL_FORMAT: cfg_q.pixel_format    <= cfg_wdata_i[1:0];
        CFG_SKIP_NEAR:    cfg_q.skip_near_color <= cfg_wdata_i[0];
        CFG_CLIP_BOX:     cfg_q.clip_box        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless the output beat is waiting
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  gabc_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  gabc_test u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  gabc_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |-> out_data_o.new_pixel == '0)
    else $error("dropped beat carries a nonzero pixel");

  a_565_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable && cfg_q.pixel_format == FMT_RGB565
    |-> out_data_o.new_pixel[31:16] == '0)
    else $error("rgb565 result has upper bits set");

  a_32_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable && cfg_q.pixel_format == FMT_BGRA32
    |-> out_data_o.new_pixel[31:24] == ALPHA_OPAQUE)
    else $error("32-bit result lacks opaque alpha");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cfg_q.frame_width == '0 || cfg_q.frame_height == '0)
    |-> !out_data_o.write_enable)
    else $error("write issued with an empty frame");

endmodule

### test/tb_glyph_alpha_blend_clip_top.sv
// ----------------------------------------------------------------------------
// tb_glyph_alpha_blend_clip_top
// Self-checking bench for the glyph alpha blend and clip pipeline. A directed
// table covers the frame and clip edges, the zero coverage, the unsupported
// format and the near-color skip in both formats. Random phases with random
// register settings and handshake idling follow. Every result beat is
// compared with the row's own value for typed rows, else with a blend predictor on a shadow of the registers.
// ----------------------------------------------------------------------------
module tb_glyph_alpha_blend_clip_top;
  import gabc_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int PIPE_DEPTH      = 3;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int CYC_LIMIT       = 400000;

  localparam gabc_out_t NO_WRITE = '0;

  typedef struct {
    gabc_cfg_t cfg;
    gabc_in_t  px;
    bit        typed;
    gabc_out_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  gabc_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  gabc_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  gabc_cfg_t   cfg_sh = '0;
  gabc_out_t   blend_exp_q[$];
  gabc_out_t   oldest;
  dir_row_t    dir_rows[$];
  bit          row_typed = 1'b0;
  gabc_out_t   row_want = '0;
  int          beats_in = 0;
  int          err_cnt = 0;
  int          cyc_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  glyph_alpha_blend_clip_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic int mix_chan(int c, int t, int a);
    return c + ((t - c) * a) / 255;
  endfunction

  function automatic bit close_to(int d, int tol);
    return d > -tol && d < tol;
  endfunction

  function automatic gabc_out_t blend_pixel(gabc_in_t px, gabc_cfg_t c);
    int        fx, fy, cx, cy, cw, ch, tr, tg, tb, r, g, b, a;
    bit        ok;
    gabc_out_t o;
    o  = NO_WRITE;
    fx = int'($signed(px.origin_x)) + int'(px.glyph_col);
    fy = int'($signed(px.origin_y)) + int'(px.glyph_row);
    cx = int'(c.clip_box[63:48]);
    cy = int'(c.clip_box[47:32]);
    cw = int'(c.clip_box[31:16]);
    ch = int'(c.clip_box[15:0]);
    tr = int'(c.text_color[23:16]);
    tg = int'(c.text_color[15:8]);
    tb = int'(c.text_color[7:0]);
    a  = int'(px.coverage);
    ok = 1'b1;
    if (int'(px.glyph_col) >= int'(GLYPH_MAX_SIDE) ||
        int'(px.glyph_row) >= int'(GLYPH_MAX_SIDE)) ok = 1'b0;
    if (c.frame_width == 0 || c.frame_height == 0) ok = 1'b0;
    if (fx < 0 || fx >= int'(c.frame_width)) ok = 1'b0;
    if (fy < 0 || fy >= int'(c.frame_height)) ok = 1'b0;
    // clip extent is taken without wrap
    if (cw > 0 && ch > 0) begin
      if (fy < cy || fy >= cy + ch) ok = 1'b0;
      if (fx < cx || fx >= cx + cw) ok = 1'b0;
    end
    if (a == 0) ok = 1'b0;
    if (c.pixel_format != FMT_RGB565 && c.pixel_format != FMT_BGRA32) ok = 1'b0;
    if (!ok) return o;
    if (c.pixel_format == FMT_RGB565) begin
      r = int'({px.dest_pixel[15:11], 3'b000});
      g = int'({px.dest_pixel[10:5], 2'b00});
      b = int'({px.dest_pixel[4:0], 3'b000});
      if (c.skip_near_color && close_to(r - tr, int'(TOL_RB_565)) &&
          close_to(g - tg, int'(TOL_G_565)) && close_to(b - tb, int'(TOL_RB_565)))
        return o;
      r = mix_chan(r, tr, a);
      g = mix_chan(g, tg, a);
      b = mix_chan(b, tb, a);
      o.new_pixel = {16'h0000, r[7:3], g[7:2], b[7:3]};
    end else begin
      b = int'(px.dest_pixel[7:0]);
      g = int'(px.dest_pixel[15:8]);
      r = int'(px.dest_pixel[23:16]);
      if (c.skip_near_color && close_to(r - tr, int'(TOL_32)) &&
          close_to(g - tg, int'(TOL_32)) && close_to(b - tb, int'(TOL_32)))
        return o;
      r = mix_chan(r, tr, a);
      g = mix_chan(g, tg, a);
      b = mix_chan(b, tb, a);
      o.new_pixel = {ALPHA_OPAQUE, r[7:0], g[7:0], b[7:0]};
    end
    o.write_enable = 1'b1;
    return o;
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (blend_exp_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, out_data_o);
          err_cnt++;
        end else begin
          oldest = blend_exp_q.pop_front();
          if (out_data_o.write_enable !== oldest.write_enable) begin
            $display("%0t: write_enable expected %b actual %b", $time,
                     oldest.write_enable, out_data_o.write_enable);
            err_cnt++;
          end
          if (out_data_o.new_pixel !== oldest.new_pixel) begin
            $display("%0t: new_pixel expected %h actual %h", $time,
                     oldest.new_pixel, out_data_o.new_pixel);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        blend_exp_q.insert(blend_exp_q.size(),
                           row_typed ? row_want : blend_pixel(in_data_i, cfg_sh));
        beats_in++;
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- stimulus
  function automatic gabc_in_t mk_px(int ox, int oy, int col, int row, int cov,
                                     logic [31:0] dst);
    gabc_in_t p;
    p.origin_x   = ox[15:0];
    p.origin_y   = oy[15:0];
    p.glyph_col  = col[7:0];
    p.glyph_row  = row[7:0];
    p.coverage   = cov[7:0];
    p.dest_pixel = dst;
    return p;
  endfunction

  function automatic gabc_cfg_t mk_cfg(logic [23:0] text, int fw, int fh,
                                       logic [1:0] fmt, logic skip, logic [63:0] clip);
    gabc_cfg_t c;
    c.text_color      = text;
    c.frame_width     = fw[15:0];
    c.frame_height    = fh[15:0];
    c.pixel_format    = fmt;
    c.skip_near_color = skip;
    c.clip_box        = clip;
    return c;
  endfunction

  task automatic add_row(gabc_cfg_t c, gabc_in_t px, bit typed, gabc_out_t want);
    dir_row_t r;
    r.cfg   = c;
    r.px    = px;
    r.typed = typed;
    r.want  = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  function automatic int pick_side();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return 1;
    return $urandom_range(1, 700);
  endfunction

  function automatic gabc_cfg_t rand_cfg(int k);
    gabc_cfg_t c;
    int        fw, fh, cx, cy, cw, ch, r;
    fw = pick_side();
    fh = pick_side();
    c.text_color   = 24'($urandom);
    c.frame_width  = fw[15:0];
    c.frame_height = fh[15:0];
    r = $urandom_range(9);
    if (r == 0) c.pixel_format = 2'd2;
    else if (r < 5) c.pixel_format = FMT_RGB565;
    else c.pixel_format = FMT_BGRA32;
    c.skip_near_color = 1'($urandom_range(1));
    if ($urandom_range(1)) begin
      c.clip_box = '0;
    end else begin
      cx = $urandom_range(0, fw);
      cy = $urandom_range(0, fh);
      cw = $urandom_range(0, 300);
      ch = $urandom_range(0, 300);
      c.clip_box = {cx[15:0], cy[15:0], cw[15:0], ch[15:0]};
    end
    if (k == 0) c = mk_cfg(24'hFFFFFF, 65535, 65535, FMT_BGRA32, 1'b1, '0);
    if (k == 1) c = mk_cfg(24'h000000, 1, 1, FMT_RGB565, 1'b0, {16'd0, 16'd0, 16'd1, 16'd1});
    return c;
  endfunction

  function automatic int sat8(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic gabc_in_t rand_px(gabc_cfg_t c);
    gabc_in_t p;
    int       fw, fh, cx, cy, cw, ch, tx, ty, ox, oy, r, rr, gg, bb, spread;
    logic [7:0] r8, g8, b8;
    fw = int'(c.frame_width);
    fh = int'(c.frame_height);
    cx = int'(c.clip_box[63:48]);
    cy = int'(c.clip_box[47:32]);
    cw = int'(c.clip_box[31:16]);
    ch = int'(c.clip_box[15:0]);
    p.glyph_col  = 8'($urandom);
    p.glyph_row  = 8'($urandom);
    p.dest_pixel = $urandom;
    p.origin_x   = 16'($urandom);
    p.origin_y   = 16'($urandom);
    r = $urandom_range(9);
    if (r == 0) p.coverage = 8'd0;
    else if (r == 1) p.coverage = 8'd255;
    else p.coverage = 8'($urandom_range(1, 255));
    // most beats aimed inside the frame, or inside the clip box when active
    if ($urandom_range(99) < 80 && fw != 0 && fh != 0) begin
      if (cw > 0 && ch > 0 && $urandom_range(1)) begin
        tx = cx + $urandom_range(0, cw - 1);
        ty = cy + $urandom_range(0, ch - 1);
      end else begin
        tx = $urandom_range(0, fw - 1);
        ty = $urandom_range(0, fh - 1);
      end
      ox = tx - int'(p.glyph_col);
      oy = ty - int'(p.glyph_row);
      p.origin_x = ox[15:0];
      p.origin_y = oy[15:0];
    end
    if (c.skip_near_color && $urandom_range(1)) begin
      spread = (c.pixel_format == FMT_RGB565) ? 8 : 30;
      rr = sat8(int'(c.text_color[23:16]) + $urandom_range(0, 2 * spread) - spread);
      gg = sat8(int'(c.text_color[15:8]) + $urandom_range(0, 2 * spread) - spread);
      bb = sat8(int'(c.text_color[7:0]) + $urandom_range(0, 2 * spread) - spread);
      r8 = rr[7:0];
      g8 = gg[7:0];
      b8 = bb[7:0];
      if (c.pixel_format == FMT_RGB565)
        p.dest_pixel[15:0] = {r8[7:3], g8[7:2], b8[7:3]};
      else
        p.dest_pixel[23:0] = {r8, g8, b8};
    end
    return p;
  endfunction

  task automatic write_reg(gabc_cfg_idx_e idx, logic [63:0] d);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = d;
    @(negedge clk_i);
  endtask

  // registers change only with the pipe empty
  task automatic apply_cfg(gabc_cfg_t c, bit junk);
    logic [63:0] j;
    in_valid_i = 1'b0;
    while (blend_exp_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 1) @(negedge clk_i);
    j = junk ? {$urandom, $urandom} : '0;
    write_reg(CFG_TEXT_COLOR, {j[63:24], c.text_color});
    write_reg(CFG_FRAME_WIDTH, {j[63:16], c.frame_width});
    write_reg(CFG_FRAME_HEIGHT, {j[63:16], c.frame_height});
    write_reg(CFG_PIXEL_FORMAT, {j[63:2], c.pixel_format});
    write_reg(CFG_SKIP_NEAR, {j[63:1], c.skip_near_color});
    write_reg(CFG_CLIP_BOX, c.clip_box);
    cfg_we_i = 1'b0;
    cfg_sh   = c;
  endtask

  task automatic send_px(gabc_in_t px, bit typed, gabc_out_t want);
    int seen;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_data_i  = px;
    row_typed  = typed;
    row_want   = want;
    in_valid_i = 1'b1;
    seen = beats_in;
    do @(negedge clk_i); while (beats_in == seen);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 74; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 74; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  initial begin
    gabc_cfg_t f565, f32, fbad, sk32, sk565, sk565b, clipc, cfull, cwide;
    f565   = mk_cfg(24'hFF8040, 640, 480, FMT_RGB565, 1'b0, '0);
    f32    = mk_cfg(24'h123456, 640, 480, FMT_BGRA32, 1'b0, '0);
    fbad   = mk_cfg(24'h123456, 640, 480, 2'd2, 1'b0, '0);
    sk32   = mk_cfg(24'h808080, 640, 480, FMT_BGRA32, 1'b1, '0);
    sk565  = mk_cfg(24'h838480, 640, 480, FMT_RGB565, 1'b1, '0);
    sk565b = mk_cfg(24'h848580, 640, 480, FMT_RGB565, 1'b1, '0);
    clipc  = mk_cfg(24'hFFFFFF, 640, 480, FMT_RGB565, 1'b0,
                    {16'd100, 16'd50, 16'd20, 16'd10});
    cfull  = mk_cfg(24'hFFFFFF, 65535, 65535, FMT_BGRA32, 1'b0, '1);
    cwide  = mk_cfg(24'hFFFFFF, 65535, 65535, FMT_BGRA32, 1'b0,
                    {16'h0, 16'h0, 16'hFFFF, 16'h0});

    // after reset the frame is zero sized
    add_row('0, mk_px(10, 10, 3, 4, 200, 32'h1234_5678), 1, NO_WRITE);
    add_row(f565, mk_px(0, 0, 0, 0, 0, 32'h0000_FFFF), 1, NO_WRITE);
    add_row(f565, mk_px(0, 0, 0, 0, 255, 32'hDEAD_0000), 1, gabc_out_t'({1'b1, 32'h0000_FC08}));
    add_row(f565, mk_px(-1, 0, 0, 0, 128, 32'h1234_ABCD), 1, NO_WRITE);
    add_row(f565, mk_px(384, 0, 255, 0, 77, 32'h0000_FFFF), 0, NO_WRITE);
    add_row(f565, mk_px(385, 0, 255, 0, 77, 32'h0000_FFFF), 1, NO_WRITE);
    add_row(f565, mk_px(0, 225, 0, 255, 1, 32'h0000_FFFF), 1, NO_WRITE);
    add_row(f565, mk_px(0, 224, 0, 255, 1, 32'h0000_FFFF), 0, NO_WRITE);
    add_row(f565, mk_px(32767, 32767, 255, 255, 255, 32'hFFFF_FFFF), 1, NO_WRITE);
    add_row(f565, mk_px(-32768, -32768, 255, 255, 255, 32'h0), 1, NO_WRITE);
    add_row(f32, mk_px(5, 5, 0, 0, 255, 32'h0), 1, gabc_out_t'({1'b1, 32'hFF12_3456}));
    add_row(f32, mk_px(5, 5, 1, 1, 128, 32'hFFFF_FFFF), 0, NO_WRITE);
    add_row(fbad, mk_px(5, 5, 0, 0, 255, 32'h0), 1, NO_WRITE);
    // near-color skip edges: distance 23 skips, 24 writes (32-bit); 565 red/green 3/4 skip, 4/5 write
    add_row(sk32, mk_px(7, 7, 0, 0, 200, 32'h0097_9797), 1, NO_WRITE);
    add_row(sk32, mk_px(7, 7, 0, 0, 200, 32'hAA98_9898), 0, NO_WRITE);
    add_row(sk32, mk_px(7, 7, 0, 0, 200, 32'h0069_6969), 1, NO_WRITE);
    add_row(sk565, mk_px(7, 7, 0, 0, 200, 32'h0000_8410), 1, NO_WRITE);
    add_row(sk565b, mk_px(7, 7, 0, 0, 200, 32'h0000_8410), 0, NO_WRITE);
    // clip box edges
    add_row(clipc, mk_px(99, 55, 0, 0, 255, 32'h0), 1, NO_WRITE);
    add_row(clipc, mk_px(100, 50, 0, 0, 255, 32'h0), 0, NO_WRITE);
    add_row(clipc, mk_px(100, 50, 19, 9, 255, 32'h0), 0, NO_WRITE);
    add_row(clipc, mk_px(120, 55, 0, 0, 255, 32'h0), 1, NO_WRITE);
    add_row(clipc, mk_px(110, 60, 0, 0, 255, 32'h0), 1, NO_WRITE);
    // box reaching past the frame, then one with zero height
    add_row(cfull, mk_px(32767, 32767, 255, 255, 255, 32'h0), 1, NO_WRITE);
    add_row(cwide, mk_px(32767, 32767, 255, 255, 255, 32'h0), 1,
            gabc_out_t'({1'b1, 32'hFFFF_FFFF}));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_idling(3);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cfg_sh) apply_cfg(dir_rows[i].cfg, 1'b0);
      send_px(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int k = 0; k < NUM_PHASES; k++) begin
      set_idling(k);
      apply_cfg(rand_cfg(k), 1'b1);
      repeat (ITEMS_PER_PHASE) send_px(rand_px(cfg_sh), 1'b0, NO_WRITE);
    end

    in_valid_i = 1'b0;
    while (blend_exp_q.size() != 0) @(negedge clk_i);
    repeat (2 * PIPE_DEPTH + 4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("** glyph_alpha_blend_clip_top: PASSED **");
    end else begin
      $display("** glyph_alpha_blend_clip_top: FAILED **");
    end
    $finish;
  end

  initial begin
    while (cyc_cnt < CYC_LIMIT) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles", $time, cyc_cnt);
    $display("** glyph_alpha_blend_clip_top: FAILED **");
    $finish;
  end

endmodule
